FILE: rtl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers of the complex arithmetic unit
// Action codes, queue entry layout, saturation and divider step functions.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QBITS     = 33;            // quotient bits kept by the divider
    localparam int NW        = 64 + QBITS;    // divider remainder width

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_NEG = 3'd4;
    localparam logic [2:0] ACT_CMP = 3'd5;

    typedef enum logic [2:0] {
        K_ADD, K_SUB, K_MUL, K_DIV, K_NEG, K_CMP, K_NONE
    } t_kind;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        t_word val;
        logic  sat;
    } t_sat;

    typedef struct packed {
        t_kind kind;
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word s_re;
        t_word s_im;
        logic  s_eq;
        logic  s_sat;
    } t_entry;

    typedef struct packed {
        logic [NW-1:0]    rem;
        logic [QBITS-1:0] quo;
        logic             neg;
        logic             ov;
    } t_dlane;

    localparam logic signed [64:0] W_MAX = 65'sd2147483647;
    localparam logic signed [64:0] W_MIN = -65'sd2147483648;

    function automatic t_sat clamp65(input logic signed [64:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = t_word'(v);
        if (v > W_MAX) begin
            r.sat = 1'b1;
            r.val = t_word'(W_MAX);
        end else if (v < W_MIN) begin
            r.sat = 1'b1;
            r.val = t_word'(W_MIN);
        end
        return r;
    endfunction

    // one restoring step: quotient shifts in MSB first
    function automatic t_dlane div_step(input t_dlane l, input logic [NW-1:0] dsh);
        t_dlane    r;
        logic [NW:0] trial;
        r     = l;
        trial = {1'b0, l.rem} - {1'b0, dsh};
        if (!trial[NW]) begin
            r.rem = trial[NW-1:0];
            r.quo = {l.quo[QBITS-2:0], 1'b1};
        end else begin
            r.quo = {l.quo[QBITS-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_sat div_result(input t_dlane l);
        t_sat r;
        r.sat = 1'b0;
        r.val = '0;
        if (l.ov) begin
            r.sat = 1'b1;
            r.val = l.neg ? t_word'(W_MIN) : t_word'(W_MAX);
        end else if (l.neg) begin
            if (l.quo > 33'h0_8000_0000) begin
                r.sat = 1'b1;
                r.val = t_word'(W_MIN);
            end else begin
                r.val = t_word'(32'd0 - l.quo[31:0]);
            end
        end else begin
            if (l.quo > 33'h0_7FFF_FFFF) begin
                r.sat = 1'b1;
                r.val = t_word'(W_MAX);
            end else begin
                r.val = t_word'(l.quo[31:0]);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/cau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_if: request and response channels
// Valid/ready channels carrying operands in and results out.
// ----------------------------------------------------------------------------
interface cau_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] x_re;
    logic signed [31:0] x_im;
    logic signed [31:0] y_re;
    logic signed [31:0] y_im;

    modport source (output valid, action, x_re, x_im, y_re, y_im, input ready);
    modport sink   (input valid, action, x_re, x_im, y_re, y_im, output ready);
endinterface

interface cau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               is_equal;
    logic               div_by_zero;
    logic               saturated;

    modport source (output valid, res_re, res_im, is_equal, div_by_zero, saturated,
                    input ready);
    modport sink   (input valid, res_re, res_im, is_equal, div_by_zero, saturated,
                    output ready);
endinterface

FILE: rtl/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: request intake
// Decodes the action, resolves add/sub/negate/compare and pushes the entry.
// ----------------------------------------------------------------------------
module cau_front (
    cau_req_if.sink         i_req,
    input  logic            i_full,
    output logic            o_push,
    output cau_pkg::t_entry o_entry
);

    logic signed [64:0] w_a, w_b, w_c, w_d;
    cau_pkg::t_sat      w_re, w_im;

    assign i_req.ready = ~i_full;
    assign o_push      = i_req.valid & ~i_full;

    assign w_a = 65'(i_req.x_re);
    assign w_b = 65'(i_req.x_im);
    assign w_c = 65'(i_req.y_re);
    assign w_d = 65'(i_req.y_im);

    always_comb begin
        o_entry      = '0;
        o_entry.a    = i_req.x_re;
        o_entry.b    = i_req.x_im;
        o_entry.c    = i_req.y_re;
        o_entry.d    = i_req.y_im;
        w_re         = '0;
        w_im         = '0;
        unique case (i_req.action)
            cau_pkg::ACT_ADD: begin
                o_entry.kind = cau_pkg::K_ADD;
                w_re = cau_pkg::clamp65(w_a + w_c);
                w_im = cau_pkg::clamp65(w_b + w_d);
            end
            cau_pkg::ACT_SUB: begin
                o_entry.kind = cau_pkg::K_SUB;
                w_re = cau_pkg::clamp65(w_a - w_c);
                w_im = cau_pkg::clamp65(w_b - w_d);
            end
            cau_pkg::ACT_MUL: o_entry.kind = cau_pkg::K_MUL;
            cau_pkg::ACT_DIV: o_entry.kind = cau_pkg::K_DIV;
            cau_pkg::ACT_NEG: begin
                o_entry.kind = cau_pkg::K_NEG;
                w_re = cau_pkg::clamp65(-w_a);
                w_im = cau_pkg::clamp65(-w_b);
            end
            cau_pkg::ACT_CMP: begin
                o_entry.kind = cau_pkg::K_CMP;
                o_entry.s_eq = (i_req.x_re == i_req.y_re) && (i_req.x_im == i_req.y_im);
            end
            default: o_entry.kind = cau_pkg::K_NONE;
        endcase
        o_entry.s_re  = w_re.val;
        o_entry.s_im  = w_im.val;
        o_entry.s_sat = w_re.sat | w_im.sat;
    end

endmodule

FILE: rtl/cau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_queue: decoupling queue
// Small register FIFO between intake and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module cau_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cau_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output cau_pkg::t_entry o_entry
);

    cau_pkg::t_entry         r_mem [cau_pkg::QDEPTH];
    logic [cau_pkg::QAW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [cau_pkg::QAW:0]   r_cnt, n_cnt;
    logic                    w_pop;

    assign o_full  = (r_cnt == (cau_pkg::QAW+1)'(cau_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];
    assign w_pop   = i_pop & ~o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == cau_pkg::QAW'(cau_pkg::QDEPTH-1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == cau_pkg::QAW'(cau_pkg::QDEPTH-1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

FILE: rtl/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back: arithmetic pipeline
// Products, sums, setup, radix-2 restoring divider stages and output register.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cau_pkg::t_entry i_entry,
    output logic            o_pop,
    cau_rsp_if.source       o_rsp
);

    typedef struct packed {
        cau_pkg::t_kind     kind;
        cau_pkg::t_word     s_re;
        cau_pkg::t_word     s_im;
        logic               s_eq;
        logic               s_sat;
        logic signed [63:0] ac, bd, ad, bc, cc, dd;
    } t_p1;

    typedef struct packed {
        cau_pkg::t_kind     kind;
        cau_pkg::t_word     s_re;
        cau_pkg::t_word     s_im;
        logic               s_eq;
        logic               s_sat;
        logic signed [64:0] num_re;
        logic signed [64:0] num_im;
        logic [63:0]        den;
    } t_p2;

    typedef struct packed {
        cau_pkg::t_kind  kind;
        cau_pkg::t_word  re;
        cau_pkg::t_word  im;
        logic            eq;
        logic            sat;
        logic            dz;
        logic [63:0]     den;
        cau_pkg::t_dlane lre;
        cau_pkg::t_dlane lim;
    } t_ds;

    logic w_adv;
    logic r_p1_v, r_p2_v;
    t_p1  r_p1;
    t_p2  r_p2;
    logic r_dv [cau_pkg::QBITS+1];
    t_ds  r_ds [cau_pkg::QBITS+1];
    t_ds  w_ds0;

    logic               r_out_v;
    cau_pkg::t_word     r_out_re, r_out_im;
    logic               r_out_eq, r_out_dz, r_out_sat;

    // whole pipeline moves together; output register frees it
    assign w_adv = ~r_out_v | o_rsp.ready;
    assign o_pop = w_adv & i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_dv[0] <= 1'b0;
        end else if (w_adv) begin
            r_p1_v  <= i_valid;
            r_p2_v  <= r_p1_v;
            r_dv[0] <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1.kind  <= i_entry.kind;
            r_p1.s_re  <= i_entry.s_re;
            r_p1.s_im  <= i_entry.s_im;
            r_p1.s_eq  <= i_entry.s_eq;
            r_p1.s_sat <= i_entry.s_sat;
            r_p1.ac    <= $signed(i_entry.a) * $signed(i_entry.c);
            r_p1.bd    <= $signed(i_entry.b) * $signed(i_entry.d);
            r_p1.ad    <= $signed(i_entry.a) * $signed(i_entry.d);
            r_p1.bc    <= $signed(i_entry.b) * $signed(i_entry.c);
            r_p1.cc    <= $signed(i_entry.c) * $signed(i_entry.c);
            r_p1.dd    <= $signed(i_entry.d) * $signed(i_entry.d);

            r_p2.kind  <= r_p1.kind;
            r_p2.s_re  <= r_p1.s_re;
            r_p2.s_im  <= r_p1.s_im;
            r_p2.s_eq  <= r_p1.s_eq;
            r_p2.s_sat <= r_p1.s_sat;
            r_p2.den   <= 64'(r_p1.cc) + 64'(r_p1.dd);
            if (r_p1.kind == cau_pkg::K_DIV) begin
                r_p2.num_re <= 65'(r_p1.ac) + 65'(r_p1.bd);
                r_p2.num_im <= 65'(r_p1.bc) - 65'(r_p1.ad);
            end else begin
                r_p2.num_re <= 65'(r_p1.ac) - 65'(r_p1.bd);
                r_p2.num_im <= 65'(r_p1.ad) + 65'(r_p1.bc);
            end

            r_ds[0] <= w_ds0;
        end
    end

    // setup: multiply results, divider operands and overflow pre-check
    always_comb begin
        logic signed [64:0] w_mag_re, w_mag_im;
        logic [cau_pkg::NW-1:0] w_dtop;
        cau_pkg::t_sat w_mre, w_mim;
        w_mre    = cau_pkg::clamp65(r_p2.num_re >>> cau_pkg::FRAC_BITS);
        w_mim    = cau_pkg::clamp65(r_p2.num_im >>> cau_pkg::FRAC_BITS);
        w_mag_re = r_p2.num_re[64] ? -r_p2.num_re : r_p2.num_re;
        w_mag_im = r_p2.num_im[64] ? -r_p2.num_im : r_p2.num_im;
        w_dtop   = cau_pkg::NW'(r_p2.den) << cau_pkg::QBITS;

        w_ds0      = '0;
        w_ds0.kind = r_p2.kind;
        w_ds0.den  = r_p2.den;
        w_ds0.eq   = r_p2.s_eq;
        w_ds0.dz   = (r_p2.kind == cau_pkg::K_DIV) && (r_p2.den == '0);
        if (r_p2.kind == cau_pkg::K_MUL) begin
            w_ds0.re  = w_mre.val;
            w_ds0.im  = w_mim.val;
            w_ds0.sat = w_mre.sat | w_mim.sat;
        end else begin
            w_ds0.re  = r_p2.s_re;
            w_ds0.im  = r_p2.s_im;
            w_ds0.sat = r_p2.s_sat;
        end
        w_ds0.lre.rem = cau_pkg::NW'(w_mag_re[63:0]) << cau_pkg::FRAC_BITS;
        w_ds0.lim.rem = cau_pkg::NW'(w_mag_im[63:0]) << cau_pkg::FRAC_BITS;
        w_ds0.lre.neg = r_p2.num_re[64];
        w_ds0.lim.neg = r_p2.num_im[64];
        w_ds0.lre.ov  = (w_ds0.lre.rem >= w_dtop);
        w_ds0.lim.ov  = (w_ds0.lim.rem >= w_dtop);
    end

    for (genvar j = 0; j < cau_pkg::QBITS; j++) begin : g_div
        logic [cau_pkg::NW-1:0] w_dsh;
        t_ds                    n_ds;
        assign w_dsh = cau_pkg::NW'(r_ds[j].den) << (cau_pkg::QBITS - 1 - j);

        always_comb begin
            n_ds     = r_ds[j];
            n_ds.lre = cau_pkg::div_step(r_ds[j].lre, w_dsh);
            n_ds.lim = cau_pkg::div_step(r_ds[j].lim, w_dsh);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ds[j+1] <= n_ds;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_dv[cau_pkg::QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        cau_pkg::t_sat w_qre, w_qim;
        w_qre = cau_pkg::div_result(r_ds[cau_pkg::QBITS].lre);
        w_qim = cau_pkg::div_result(r_ds[cau_pkg::QBITS].lim);
        if (w_adv) begin
            r_out_eq <= r_ds[cau_pkg::QBITS].eq;
            r_out_dz <= r_ds[cau_pkg::QBITS].dz;
            if (r_ds[cau_pkg::QBITS].kind != cau_pkg::K_DIV) begin
                r_out_re  <= r_ds[cau_pkg::QBITS].re;
                r_out_im  <= r_ds[cau_pkg::QBITS].im;
                r_out_sat <= r_ds[cau_pkg::QBITS].sat;
            end else if (r_ds[cau_pkg::QBITS].dz) begin
                r_out_re  <= '0;
                r_out_im  <= '0;
                r_out_sat <= 1'b0;
            end else begin
                r_out_re  <= w_qre.val;
                r_out_im  <= w_qim.val;
                r_out_sat <= w_qre.sat | w_qim.sat;
            end
        end
    end

    assign o_rsp.valid       = r_out_v;
    assign o_rsp.res_re      = r_out_re;
    assign o_rsp.res_im      = r_out_im;
    assign o_rsp.is_equal    = r_out_eq;
    assign o_rsp.div_by_zero = r_out_dz;
    assign o_rsp.saturated   = r_out_sat;

endmodule

FILE: rtl/complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core: complex Q16.16 arithmetic unit
// Add, subtract, multiply, divide, negate and compare on complex operands.
// ----------------------------------------------------------------------------
// One request per clock is accepted while the queue has room, and one
// response per request comes out in order. A request passes through a queue
// slot, two multiply/sum stages, a setup stage, 33 stages of the radix-2
// restoring divider (one quotient bit per stage) and the output register.
// Every action takes the same path, the divider stages included. When the
// response is held the pipeline freezes and the 4-entry queue keeps taking
// requests until it is full.
module complex_arithmetic_unit_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_req_if.sink   i_req,
    cau_rsp_if.source o_rsp
);

    logic            w_push, w_full, w_pop, w_empty;
    cau_pkg::t_entry w_in_entry, w_q_entry;

    cau_front u_front (
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_in_entry)
    );

    cau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_entry (w_q_entry)
    );

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (~w_empty),
        .i_entry (w_q_entry),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: rtl/cau_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_chk: port checker
// Response consistency checks, bound onto the core.
// ----------------------------------------------------------------------------
module cau_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_res_re,
    input logic [31:0] i_res_im,
    input logic        i_eq,
    input logic        i_dz,
    input logic        i_sat
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_res_re) && $stable(i_res_im))
        else $error("response changed while stalled");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dz |-> i_res_re == '0 && i_res_im == '0 && !i_sat && !i_eq)
        else $error("divide by zero response not clean");

    a_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_eq |-> i_res_re == '0 && i_res_im == '0 && !i_sat && !i_dz)
        else $error("compare response not clean");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_sat |-> i_res_re == 32'h7FFF_FFFF || i_res_re == 32'h8000_0000 ||
                             i_res_im == 32'h7FFF_FFFF || i_res_im == 32'h8000_0000)
        else $error("saturated flag without clamped part");

endmodule

bind complex_arithmetic_unit_core cau_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_res_re (o_rsp.res_re),
    .i_res_im (o_rsp.res_im),
    .i_eq     (o_rsp.is_equal),
    .i_dz     (o_rsp.div_by_zero),
    .i_sat    (o_rsp.saturated)
);
